FILE: hdl/circular_orbit_to_cartesian_assert.svh
// Assertion macros for the orbit to Cartesian pipeline, clocked on clk, off during reset.
`ifndef CIRCULAR_ORBIT_TO_CARTESIAN_ASSERT_SVH
`define CIRCULAR_ORBIT_TO_CARTESIAN_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define COTC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("orbit to cartesian assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define COTC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("orbit to cartesian assertion failed");

`endif

FILE: hdl/cotc_pkg.sv
// Shared constants, tables and rounding helper for the orbit to Cartesian pipeline.
`default_nettype none
package cotc_pkg;

	localparam int DEF_ANGLE_BITS  = 16;
	localparam int DEF_RADIUS_BITS = 24;
	localparam int TURN_BITS       = 32;
	localparam int HORNER_STEPS    = 7;
	// fold, x, x^2, three stages per Horner step, final product
	localparam int SINE_LAT        = 3 * HORNER_STEPS + 4;
	localparam int COMB_LAT        = 5;
	localparam int PROD_W          = 66;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	localparam logic [30:0] PIH_Q30 = 31'd1686629713;

	// Horner divisors of the sine series
	function automatic logic [7:0] horner_div(input int k);
		logic [7:0] d;
		case (k)
			0: d = 8'd210;
			1: d = 8'd156;
			2: d = 8'd110;
			3: d = 8'd72;
			4: d = 8'd42;
			5: d = 8'd20;
			default: d = 8'd6;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor), estimate is at most one short of the quotient
	function automatic logic [29:0] horner_recip(input int k);
		logic [29:0] m;
		case (k)
			0: m = 30'd20452225;
			1: m = 30'd27531841;
			2: m = 30'd39045157;
			3: m = 30'd59652323;
			4: m = 30'd102261126;
			5: m = 30'd214748364;
			default: m = 30'd715827882;
		endcase
		return m;
	endfunction

	// Round v / 2^30 half away from zero
	function automatic logic signed [PROD_W-1:0] round_q30(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] r;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (mag + PROD_W'(66'h2000_0000)) >> 30;
		return v[PROD_W-1] ? $signed(-r) : $signed(r);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/cotc_sine.sv
// Pipelined Q30 sine of a 32-bit turn fraction, polynomial by Horner steps.
`default_nettype none
module cotc_sine
	import cotc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic [TURN_BITS-1:0] turn,
	output logic signed [31:0]        sine
);

	localparam int HSTG = 3 * HORNER_STEPS;
	localparam logic [61:0] HALF62 = 62'h2000_0000;
	localparam logic [63:0] HALF64 = 64'h2000_0000;

	logic [30:0] arg;
	logic [30:0] arg_s1;
	logic        neg_s1;
	logic [61:0] x_prod;
	logic [30:0] x_s2;
	logic        neg_s2;
	logic [61:0] x2_prod;
	logic [30:0] x_pipe  [0:HSTG];
	logic        sg_pipe [0:HSTG];
	logic [31:0] x2_pipe [0:HSTG-3];
	logic [30:0] t_c     [0:HORNER_STEPS-1];
	logic [61:0] f_prod;
	logic [31:0] f_val;
	logic [30:0] f_mag;

	// fold the angle onto the first quadrant
	always_comb begin
		arg = turn[30] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
	end

	always_ff @(posedge clk) begin
		arg_s1 <= arg;
		neg_s1 <= turn[31];
	end

	// scale to Q30 radians
	assign x_prod = 62'(arg_s1) * 62'(PIH_Q30);

	always_ff @(posedge clk) begin
		x_s2   <= 31'((x_prod + HALF62) >> 30);
		neg_s2 <= neg_s1;
	end

	// square of the argument
	assign x2_prod = 62'(x_s2) * 62'(x_s2);

	always_ff @(posedge clk) begin
		x_pipe[0]  <= x_s2;
		sg_pipe[0] <= neg_s2;
		x2_pipe[0] <= 32'((x2_prod + HALF62) >> 30);
	end

	// carry argument and sign alongside the Horner steps
	always_ff @(posedge clk) begin
		for (int j = 0; j < HSTG; j++) begin
			x_pipe[j+1]  <= x_pipe[j];
			sg_pipe[j+1] <= sg_pipe[j];
		end
		for (int j = 0; j < HSTG - 3; j++) begin
			x2_pipe[j+1] <= x2_pipe[j];
		end
	end

	for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
		localparam logic [7:0]  DIV   = horner_div(k);
		localparam logic [29:0] RECIP = horner_recip(k);
		logic [30:0] t_in;
		logic [31:0] p_a;
		logic [31:0] p_b;
		logic [29:0] q0_b;
		logic [39:0] rem;
		logic [30:0] quo;

		if (k == 0) begin : g_first
			assign t_in = Q30_ONE;
		end else begin : g_next
			assign t_in = t_c[k-1];
		end

		// product with the running term
		always_ff @(posedge clk) begin
			p_a <= 32'((64'(x2_pipe[3*k]) * 64'(t_in) + HALF64) >> 30);
		end

		// quotient estimate by reciprocal
		always_ff @(posedge clk) begin
			q0_b <= 30'((64'(p_a) * 64'(RECIP)) >> 32);
			p_b  <= p_a;
		end

		// correct the estimate and form the next term
		always_comb begin
			rem = 40'(p_b) - 40'(q0_b) * 40'(DIV);
			quo = (rem >= 40'(DIV)) ? (31'(q0_b) + 31'd1) : 31'(q0_b);
		end

		always_ff @(posedge clk) begin
			t_c[k] <= Q30_ONE - quo;
		end
	end

	// final product, clamp and sign
	assign f_prod = 62'(x_pipe[HSTG]) * 62'(t_c[HORNER_STEPS-1]);
	assign f_val  = 32'((f_prod + HALF62) >> 30);
	assign f_mag  = (f_val > 32'(Q30_ONE)) ? Q30_ONE : f_val[30:0];

	always_ff @(posedge clk) begin
		sine <= sg_pipe[HSTG] ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
	end

endmodule
`default_nettype wire

FILE: hdl/circular_orbit_to_cartesian.sv
// Top level: circular orbit point to Cartesian position, fully pipelined.
//
// One request (radius and three binary angles) is taken on every cycle in which start is
// high; busy stays low because the pipeline never holds. Each result appears on pos_x,
// pos_y and pos_z with done high for one cycle, after passing through the six parallel
// sine units (argument scaling, squaring and seven Horner steps of multiply, reciprocal
// divide and correct) and then through the stages that combine the rotation
// coefficients, scale by the radius and saturate. The receiver cannot stall, so results
// must be taken as they come.
`default_nettype none
module circular_orbit_to_cartesian
	import cotc_pkg::*;
#(
	parameter int ANGLE_BITS  = DEF_ANGLE_BITS,
	parameter int RADIUS_BITS = DEF_RADIUS_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [RADIUS_BITS-1:0]        radius,
	input  wire logic [ANGLE_BITS-1:0]         orbit_angle,
	input  wire logic [ANGLE_BITS-1:0]         node_longitude,
	input  wire logic [ANGLE_BITS-1:0]         tilt,
	output logic                               done,
	output logic signed [RADIUS_BITS:0]        pos_x,
	output logic signed [RADIUS_BITS:0]        pos_y,
	output logic signed [RADIUS_BITS:0]        pos_z
);

	localparam int LAT   = SINE_LAT + COMB_LAT;
	localparam int OUT_W = RADIUS_BITS + 1;
	localparam logic [TURN_BITS-1:0] QUARTER = 32'h4000_0000;
	localparam logic signed [PROD_W-1:0] LIM = PROD_W'((66'd1 << RADIUS_BITS) - 66'd1);

	logic [TURN_BITS-1:0]        th_turn;
	logic [TURN_BITS-1:0]        ph_turn;
	logic [TURN_BITS-1:0]        ti_turn;
	logic [TURN_BITS-1:0]        ang      [0:5];
	logic signed [31:0]          trig     [0:5];
	logic                        vld_s    [1:LAT];
	logic [RADIUS_BITS-1:0]      rad_s    [1:LAT-2];
	logic signed [32:0]          cis_s26;
	logic signed [PROD_W-1:0]    kz_s26;
	logic signed [31:0]          cp_s26;
	logic signed [31:0]          ct_s26;
	logic signed [31:0]          sp_s26;
	logic signed [PROD_W-1:0]    pa_s27;
	logic signed [PROD_W-1:0]    pb_s27;
	logic signed [PROD_W-1:0]    pc_s27;
	logic signed [PROD_W-1:0]    pd_s27;
	logic signed [PROD_W-1:0]    kz_s27;
	logic signed [32:0]          kx_s28;
	logic signed [32:0]          ky_s28;
	logic signed [32:0]          kz_s28;
	logic signed [PROD_W-1:0]    rad_w;
	logic signed [PROD_W-1:0]    vx_s29;
	logic signed [PROD_W-1:0]    vy_s29;
	logic signed [PROD_W-1:0]    vz_s29;
	logic signed [PROD_W-1:0]    sx;
	logic signed [PROD_W-1:0]    sy;
	logic signed [PROD_W-1:0]    sz;

	assign busy = 1'b0;

	// left-align each angle to a full-turn fraction
	assign th_turn = TURN_BITS'(orbit_angle) << (TURN_BITS - ANGLE_BITS);
	assign ph_turn = TURN_BITS'(node_longitude) << (TURN_BITS - ANGLE_BITS);
	assign ti_turn = TURN_BITS'(tilt) << (TURN_BITS - ANGLE_BITS);

	// lanes: sin theta, cos theta, sin phi, cos phi, sin i, cos i
	assign ang[0] = th_turn;
	assign ang[1] = th_turn + QUARTER;
	assign ang[2] = ph_turn;
	assign ang[3] = ph_turn + QUARTER;
	assign ang[4] = ti_turn;
	assign ang[5] = ti_turn + QUARTER;

	for (genvar i = 0; i < 6; i++) begin : g_lane
		cotc_sine u_sine (
			.clk  (clk),
			.turn (ang[i]),
			.sine (trig[i])
		);
	end

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= LAT; j++) begin
				vld_s[j] <= 1'b0;
			end
		end else begin
			vld_s[1] <= start && !busy;
			for (int j = 1; j < LAT; j++) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
	end

	// hold the radius until the scaling stage
	always_ff @(posedge clk) begin
		rad_s[1] <= radius;
		for (int j = 1; j < LAT - 2; j++) begin
			rad_s[j+1] <= rad_s[j];
		end
	end

	// cos i sin theta and sin i sin theta
	always_ff @(posedge clk) begin
		cis_s26 <= 33'(round_q30(PROD_W'(trig[5]) * PROD_W'(trig[0])));
		kz_s26  <= round_q30(PROD_W'(trig[4]) * PROD_W'(trig[0]));
		cp_s26  <= trig[3];
		ct_s26  <= trig[1];
		sp_s26  <= trig[2];
	end

	// rotation products
	always_ff @(posedge clk) begin
		pa_s27 <= PROD_W'(cp_s26) * PROD_W'(ct_s26);
		pb_s27 <= PROD_W'(sp_s26) * PROD_W'(cis_s26);
		pc_s27 <= PROD_W'(sp_s26) * PROD_W'(ct_s26);
		pd_s27 <= PROD_W'(cp_s26) * PROD_W'(cis_s26);
		kz_s27 <= kz_s26;
	end

	// rotation coefficients
	always_ff @(posedge clk) begin
		kx_s28 <= 33'(round_q30(pa_s27 - pb_s27));
		ky_s28 <= 33'(round_q30(pc_s27 + pd_s27));
		kz_s28 <= 33'(kz_s27);
	end

	// scale by the radius to whole meters
	assign rad_w = PROD_W'($signed({1'b0, rad_s[LAT-2]}));

	always_ff @(posedge clk) begin
		vx_s29 <= round_q30(rad_w * PROD_W'(kx_s28));
		vy_s29 <= round_q30(rad_w * PROD_W'(ky_s28));
		vz_s29 <= round_q30(rad_w * PROD_W'(kz_s28));
	end

	// saturate to the output range
	always_comb begin
		sx = (vx_s29 > LIM) ? LIM : ((vx_s29 < -LIM) ? -LIM : vx_s29);
		sy = (vy_s29 > LIM) ? LIM : ((vy_s29 < -LIM) ? -LIM : vy_s29);
		sz = (vz_s29 > LIM) ? LIM : ((vz_s29 < -LIM) ? -LIM : vz_s29);
	end

	always_ff @(posedge clk) begin
		pos_x <= OUT_W'(sx);
		pos_y <= OUT_W'(sy);
		pos_z <= OUT_W'(sz);
	end

	assign done = vld_s[LAT];

	`include "circular_orbit_to_cartesian_assert.svh"

	`COTC_ASSERT_IMPL(a_done_from_request, done, $past(start && !busy, LAT))
	`COTC_ASSERT_IMPL(a_x_saturated, done, pos_x != {1'b1, {RADIUS_BITS{1'b0}}})
	`COTC_ASSERT_IMPL(a_z_saturated, done, pos_z != {1'b1, {RADIUS_BITS{1'b0}}})
	`COTC_ASSERT_IMPL(a_zero_radius, done && $past(radius == '0, LAT), pos_x == '0 && pos_y == '0 && pos_z == '0)
	`COTC_ASSERT_NEXT(a_never_busy, 1'b1, !busy && $stable(busy))

endmodule
`default_nettype wire
